// ===== hdl/lgge_pkg.sv =====
// ----------------------------------------------------------------------------
// Life grid generation engine package
// Shared sizes, codes, command and status types and address helpers.
// ----------------------------------------------------------------------------
package lgge_pkg;

	// Largest grid that the cell memory holds.
	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLUMNS = 64;
	localparam int GRID_CELLS  = MAX_ROWS * MAX_COLUMNS;

	// Address into the cell memory, column index into the line buffer.
	localparam int ADDR_W = $clog2(GRID_CELLS);
	localparam int COL_W  = $clog2(MAX_COLUMNS);

	// Scan counters must also hold the grid size itself.
	localparam int ROW_CW = $clog2(MAX_ROWS + 1);
	localparam int COL_CW = $clog2(MAX_COLUMNS + 1);

	// Fixed field widths of the ports.
	localparam int OP_W   = 2;
	localparam int POS_W  = 6;
	localparam int CELL_W = 2;
	localparam int CFG_W  = 7;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

	// Cell codes. The fourth code is never stored; a write of it is ignored.
	localparam logic [CELL_W-1:0] CELL_DEAD    = 2'd0;
	localparam logic [CELL_W-1:0] CELL_ALIVE   = 2'd1;
	localparam logic [CELL_W-1:0] CELL_BLOCKED = 2'd2;
	localparam logic [CELL_W-1:0] CELL_UNUSED  = 2'd3;

	// Configuration register indexes.
	localparam logic REG_GRID_COLUMNS = 1'b0;
	localparam logic REG_GRID_ROWS    = 1'b1;

	localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_GEN,
		ST_DRAIN,
		ST_RESP
	} lgge_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_en;
		logic item_load;
		logic item_exec;
		logic scan_en;
		logic result_load;
	} lgge_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic scan_last;
		logic is_advance;
	} lgge_sts_t;

	// Cells are stored row by row at row * MAX_COLUMNS + column.
	function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned r, input int unsigned c);
		return ADDR_W'(r * MAX_COLUMNS + c);
	endfunction

endpackage

// ===== hdl/lgge_ctrl.sv =====
// ----------------------------------------------------------------------------
// Life grid generation engine controller
// Sequences the clearing pass, single cell accesses, generation scans and the
// hand-off of each result word to the output register.
// ----------------------------------------------------------------------------
module lgge_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  lgge_pkg::lgge_sts_t sts,
	output lgge_pkg::lgge_cmd_t cmd
);
	import lgge_pkg::*;

	lgge_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.item_exec = 1'b1;
				state_d       = sts.is_advance ? ST_GEN : ST_RESP;
			end
			ST_GEN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					cmd.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/lgge_datapath.sv =====
// ----------------------------------------------------------------------------
// Life grid generation engine datapath
// Cell memory, grid size registers, generation scan with a line buffer and a
// three column window, and the result register.
// ----------------------------------------------------------------------------
module lgge_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lgge_pkg::lgge_cmd_t         cmd,
	output lgge_pkg::lgge_sts_t         sts,
	input  logic [lgge_pkg::OP_W-1:0]   operation,
	input  logic [lgge_pkg::POS_W-1:0]  row,
	input  logic [lgge_pkg::POS_W-1:0]  column,
	input  logic [lgge_pkg::CELL_W-1:0] cell_value,
	input  logic                        cfg_valid,
	input  logic                        cfg_index,
	input  logic [lgge_pkg::CFG_W-1:0]  cfg_data,
	output logic [lgge_pkg::CELL_W-1:0] read_value,
	output logic                        in_range
);
	import lgge_pkg::*;

	// Grid size registers and the sizes in use after saturation.
	logic [CFG_W-1:0]  grid_columns_q, grid_rows_q;
	logic [ROW_CW-1:0] used_rows;
	logic [COL_CW-1:0] used_cols;

	// Latched input word.
	logic [OP_W-1:0]   op_q;
	logic [POS_W-1:0]  row_q, col_q;
	logic [CELL_W-1:0] val_q;
	logic              in_grid;
	logic [ADDR_W-1:0] item_addr;

	// Cell memory and its ports.
	logic [CELL_W-1:0] cells [GRID_CELLS];
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata, mem_rdata_q;
	logic [ADDR_W-1:0] clr_q;

	// Line buffer: per column, live bit two rows up and state one row up.
	logic [CELL_W:0]   lbuf [MAX_COLUMNS];
	logic [CELL_W:0]   lb_rdata_q;

	// Scan issue counters and the stage that sees the read data.
	logic [ROW_CW-1:0] r_q;
	logic [COL_CW-1:0] c_q;
	logic              v_s1, first_row_s1, vcol_s1, vrow_s1;
	logic [ROW_CW-1:0] r_s1;
	logic [COL_CW-1:0] c_s1;

	// Three column window of the neighborhood.
	logic              l_top_q, l_mid_q, l_bot_q;
	logic              m_top_q, m_bot_q;
	logic [CELL_W-1:0] m_state_q;
	logic              r_top, r_mid, r_bot;
	logic [CELL_W-1:0] r_mid_state, r_bot_state;
	logic [7:0]        nbrs;
	logic [3:0]        live_cnt;
	logic [CELL_W-1:0] next_state;
	logic              wb_en;
	logic [ADDR_W-1:0] wb_addr;

	assign used_rows = (int'(grid_rows_q) > MAX_ROWS) ? ROW_CW'(MAX_ROWS)
	                                                  : ROW_CW'(grid_rows_q);
	assign used_cols = (int'(grid_columns_q) > MAX_COLUMNS) ? COL_CW'(MAX_COLUMNS)
	                                                        : COL_CW'(grid_columns_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= GRID_SIZE_RESET;
			grid_rows_q    <= GRID_SIZE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GRID_COLUMNS: grid_columns_q <= cfg_data;
				REG_GRID_ROWS:    grid_rows_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			op_q  <= operation;
			row_q <= row;
			col_q <= column;
			val_q <= cell_value;
		end
	end

	assign in_grid   = (int'(row_q) < int'(used_rows)) && (int'(col_q) < int'(used_cols));
	assign item_addr = cell_addr(int'(row_q), int'(col_q));

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_en) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end
	assign sts.clear_last = (int'(clr_q) == GRID_CELLS - 1);
	assign sts.is_advance = (op_q == OP_ADVANCE);

	// Scan counters walk one extra row and one extra column past the grid
	// so that the last row and column see dead neighbors there.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q  <= '0;
			c_q  <= '0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_en;
			if (cmd.item_load) begin
				r_q <= '0;
				c_q <= '0;
			end else if (cmd.scan_en) begin
				if (c_q == used_cols) begin
					c_q <= '0;
					r_q <= r_q + ROW_CW'(1);
				end else begin
					c_q <= c_q + COL_CW'(1);
				end
			end
		end
	end
	assign sts.scan_last = (r_q == used_rows) && (c_q == used_cols);

	always_ff @(posedge clk) begin
		if (cmd.scan_en) begin
			r_s1         <= r_q;
			c_s1         <= c_q;
			first_row_s1 <= (r_q == '0);
			vcol_s1      <= (c_q == used_cols);
			vrow_s1      <= (r_q == used_rows);
		end
	end

	// Incoming column of the window.
	assign r_top       = (first_row_s1 || vcol_s1) ? 1'b0 : lb_rdata_q[CELL_W];
	assign r_mid_state = (first_row_s1 || vcol_s1) ? CELL_DEAD : lb_rdata_q[CELL_W-1:0];
	assign r_bot_state = (vrow_s1 || vcol_s1) ? CELL_DEAD : mem_rdata_q;
	assign r_mid       = (r_mid_state == CELL_ALIVE);
	assign r_bot       = (r_bot_state == CELL_ALIVE);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			if (c_s1 == '0) begin
				l_top_q <= 1'b0;
				l_mid_q <= 1'b0;
				l_bot_q <= 1'b0;
			end else begin
				l_top_q <= m_top_q;
				l_mid_q <= (m_state_q == CELL_ALIVE);
				l_bot_q <= m_bot_q;
			end
			m_top_q   <= r_top;
			m_state_q <= r_mid_state;
			m_bot_q   <= r_bot;
		end
	end

	assign nbrs     = {l_top_q, l_mid_q, l_bot_q, m_top_q, m_bot_q, r_top, r_mid, r_bot};
	assign live_cnt = 4'($countones(nbrs));

	always_comb begin
		case (m_state_q)
			CELL_DEAD:  next_state = (live_cnt == 4'd3) ? CELL_ALIVE : CELL_DEAD;
			CELL_ALIVE: next_state = (live_cnt == 4'd2 || live_cnt == 4'd3) ? CELL_ALIVE
			                                                               : CELL_DEAD;
			default:    next_state = m_state_q;
		endcase
	end

	// The window center is the cell one row up and one column left.
	assign wb_en   = v_s1 && (r_s1 != '0) && (c_s1 != '0);
	assign wb_addr = cell_addr(int'(r_s1) - 1, int'(c_s1) - 1);

	always_ff @(posedge clk) begin
		if (v_s1 && !vcol_s1) begin
			lbuf[c_s1[COL_W-1:0]] <= {r_mid, r_bot_state};
		end
		if (cmd.scan_en) begin
			lb_rdata_q <= lbuf[c_q[COL_W-1:0]];
		end
	end

	// Cell memory port selection.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = item_addr;
		mem_wdata = val_q;
		if (cmd.clear_en) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = CELL_DEAD;
		end else if (wb_en) begin
			mem_we    = 1'b1;
			mem_waddr = wb_addr;
			mem_wdata = next_state;
		end else if (cmd.item_exec && op_q == OP_WRITE && in_grid && val_q != CELL_UNUSED) begin
			mem_we = 1'b1;
		end
	end

	assign mem_re    = cmd.scan_en || (cmd.item_exec && op_q == OP_READ);
	assign mem_raddr = cmd.scan_en ? cell_addr(int'(r_q), int'(c_q)) : item_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cells[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= cells[mem_raddr];
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			read_value <= (op_q == OP_READ && in_grid) ? mem_rdata_q : CELL_DEAD;
			in_range   <= (op_q == OP_READ || op_q == OP_WRITE) && in_grid;
		end
	end

endmodule

// ===== hdl/life_grid_generation_engine_core.sv =====
// ----------------------------------------------------------------------------
// Life grid generation engine core
// Grid of dead, alive and blocked cells with cell access and B3/S23 steps.
// ----------------------------------------------------------------------------
// The core holds a grid of up to 64 by 64 cells, each dead, alive or blocked,
// and takes one input word at a time: a cell write, a cell read, or one
// generation step, and returns one result word for each. A generation step
// scans the grid in the configured size once, one memory access per cycle.
// The extra row and column of the scan supply the dead cells beyond the
// border. The pace of the scan is set by the single read port of the cell
// memory. After reset the core clears the cell memory, one cell per cycle,
// and holds in_stall high until the clearing is done; configuration writes are
// taken at any time but must only be issued while the core is idle. A new
// input word is taken while a finished result word still waits in the output
// register.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input words.
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lgge_pkg::OP_W-1:0]   operation,
	input  logic [lgge_pkg::POS_W-1:0]  row,
	input  logic [lgge_pkg::POS_W-1:0]  column,
	input  logic [lgge_pkg::CELL_W-1:0] cell_value,
	// Result words.
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lgge_pkg::CELL_W-1:0] read_value,
	output logic                        in_range,
	// Configuration writes: index 0 is grid_columns, index 1 is grid_rows.
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [lgge_pkg::CFG_W-1:0]  cfg_data
);
	import lgge_pkg::*;

	lgge_cmd_t cmd;
	lgge_sts_t sts;

	// The size registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	// The controller steps through clearing, cell access, generation scan and
	// result hand-off; it alone drives the input and result handshakes.
	lgge_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath owns the cell memory, the line buffer of the scan, the
	// neighbor window and the result register.
	lgge_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (operation),
		.row        (row),
		.column     (column),
		.cell_value (cell_value),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.read_value (read_value),
		.in_range   (in_range)
	);

endmodule

// ===== hdl/lgge_checker.sv =====
// ----------------------------------------------------------------------------
// Life grid generation engine checker
// Port level assertions, attached to the core by a bind statement.
// ----------------------------------------------------------------------------
module lgge_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [lgge_pkg::CELL_W-1:0] read_value,
	input logic                        in_range
);
	import lgge_pkg::*;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(in_range))
		else $error("result word changed while stalled");

	// Only one word is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while one was in work");

	// A nonzero cell state only comes back from a read inside the grid.
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_value != CELL_DEAD |-> in_range)
		else $error("cell state reported outside the grid");

	// No stored cell ever holds the unused code.
	a_cell_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> read_value != CELL_UNUSED)
		else $error("invalid cell code read back");

endmodule

bind life_grid_generation_engine_core lgge_checker u_lgge_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.read_value (read_value),
	.in_range   (in_range)
);
